### rtl/exlex_pkg.sv
// Shared types, constants and helper functions for the expression lexer.
package exlex_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int POS_W    = $clog2(MAX_TEXT + 1);
  localparam int TB_W     = $clog2(MAX_TEXT);
  localparam int WIDE_W   = (POS_W > 13) ? POS_W : 13;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_OPER   = 3'd1;
  localparam logic [2:0] KIND_IDENT  = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [3:0] OP_LE    = 4'd0;
  localparam logic [3:0] OP_PLUS  = 4'd4;
  localparam logic [3:0] OP_MINUS = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_POW   = 4'd8;
  localparam logic [3:0] OP_EQ    = 4'd9;
  localparam logic [3:0] OP_LT    = 4'd10;

  // Pending operator candidates.
  localparam logic [1:0] CAND_LT  = 2'd0;
  localparam logic [1:0] CAND_GT  = 2'd1;
  localparam logic [1:0] CAND_INT = 2'd2;
  localparam logic [1:0] CAND_DRV = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_OPPEND
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } char_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] start_position;
    logic [12:0] token_length;
    logic [3:0]  operator_code;
    logic        last;
  } tok_beat_t;

  // One character can produce up to two tokens; they enter the queue together.
  typedef struct packed {
    logic [1:0] count;
    tok_beat_t  tok0;
    tok_beat_t  tok1;
  } push_t;

  // Builds a token beat, saturating position and length to the field widths.
  function automatic tok_beat_t make_tok(input logic [2:0] kind,
                                         input logic [POS_W-1:0] start,
                                         input logic [POS_W-1:0] len,
                                         input logic [3:0] code,
                                         input logic last);
    tok_beat_t t;
    logic [WIDE_W-1:0] s;
    logic [WIDE_W-1:0] l;
    s = WIDE_W'(start);
    l = WIDE_W'(len);
    t.kind           = kind;
    t.start_position = (s > WIDE_W'(4095)) ? 12'hFFF : s[11:0];
    t.token_length   = (l > WIDE_W'(8191)) ? 13'h1FFF : l[12:0];
    t.operator_code  = code;
    t.last           = last;
    return t;
  endfunction

  // Expected character of a keyword operator at a given matched count.
  function automatic logic [7:0] kw_char(input logic [1:0] cand, input logic [1:0] m);
    logic [7:0] ch;
    ch = 8'h00;
    if (cand == CAND_INT) begin
      case (m)
        2'd0:    ch = "i";
        2'd1:    ch = "n";
        default: ch = "t";
      endcase
    end else begin
      case (m)
        2'd0:    ch = "d";
        2'd1:    ch = "r";
        default: ch = "v";
      endcase
    end
    return ch;
  endfunction

endpackage

### rtl/exlex_front.sv
// Front end: accepts characters, runs the scanner state and produces tokens.
module exlex_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  exlex_pkg::char_beat_t  char_beat,
  input  logic                   room,
  output exlex_pkg::push_t       push
);
  import exlex_pkg::*;

  scan_mode_t       scan_mode, scan_mode_next;
  logic [TB_W-1:0]  token_begin, token_begin_next;
  logic [POS_W-1:0] char_position, char_position_next;
  logic [1:0]       prefix_matched, prefix_matched_next;
  logic [1:0]       prefix_candidate, prefix_candidate_next;
  logic             error_seen, error_seen_next;

  tok_beat_t        res [2];
  logic [1:0]       n;
  logic             accept;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  assign accept     = char_valid && room;
  assign char_ready = room;

  always_comb begin
    logic [7:0]       c;
    logic [POS_W-1:0] tb;
    logic [POS_W-1:0] len;
    logic [1:0]       m;
    logic             done;
    c  = char_beat.character;
    scan_mode_next        = scan_mode;
    token_begin_next      = token_begin;
    char_position_next    = char_position;
    prefix_matched_next   = prefix_matched;
    prefix_candidate_next = prefix_candidate;
    error_seen_next       = error_seen;
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    m      = 2'd0;
    done   = 1'b0;
    tb     = POS_W'(token_begin);
    len    = char_position - tb;

    if (char_beat.end_of_text) begin
      if (!error_seen && scan_mode != MODE_IDLE) begin
        if (scan_mode == MODE_NUM)
          res[n[0]] = make_tok(KIND_NUMBER, tb, len, 4'd0, 1'b0);
        else if (scan_mode == MODE_OPPEND && prefix_candidate < CAND_INT)
          res[n[0]] = make_tok(KIND_OPER, tb, POS_W'(1), OP_LT + 4'(prefix_candidate), 1'b0);
        else
          res[n[0]] = make_tok(KIND_IDENT, tb, len, 4'd0, 1'b0);
        n = n + 2'd1;
      end
      res[n[0]] = make_tok(KIND_END, char_position, '0, 4'd0, 1'b1);
      n = n + 2'd1;
      scan_mode_next        = MODE_IDLE;
      token_begin_next      = '0;
      char_position_next    = '0;
      prefix_matched_next   = '0;
      prefix_candidate_next = '0;
      error_seen_next       = 1'b0;
    end else if (error_seen) begin
      n = 2'd0;
    end else if (char_position >= POS_W'(MAX_TEXT)) begin
      if (scan_mode != MODE_IDLE) begin
        if (scan_mode == MODE_NUM)
          res[n[0]] = make_tok(KIND_NUMBER, tb, len, 4'd0, 1'b0);
        else if (scan_mode == MODE_OPPEND && prefix_candidate < CAND_INT)
          res[n[0]] = make_tok(KIND_OPER, tb, POS_W'(1), OP_LT + 4'(prefix_candidate), 1'b0);
        else
          res[n[0]] = make_tok(KIND_IDENT, tb, len, 4'd0, 1'b0);
        n = n + 2'd1;
      end
      scan_mode_next  = MODE_IDLE;
      error_seen_next = 1'b1;
      res[n[0]] = make_tok(KIND_ERROR, char_position, '0, 4'd0, 1'b0);
      n = n + 2'd1;
    end else begin
      // Resolve a pending operator first; a mismatch falls through and the
      // character is then scanned again as ordinary text.
      if (scan_mode == MODE_OPPEND) begin
        if (prefix_candidate < CAND_INT) begin
          if (c == "=") begin
            res[n[0]] = make_tok(KIND_OPER, tb, POS_W'(2), 4'(prefix_candidate), 1'b0);
            n = n + 2'd1;
            scan_mode_next = MODE_IDLE;
            done = 1'b1;
          end else begin
            res[n[0]] = make_tok(KIND_OPER, tb, POS_W'(1), OP_LT + 4'(prefix_candidate), 1'b0);
            n = n + 2'd1;
            scan_mode_next = MODE_IDLE;
          end
        end else begin
          m = (prefix_matched > 2'd2) ? 2'd2 : prefix_matched;
          if (c == kw_char(prefix_candidate, m)) begin
            prefix_matched_next = m + 2'd1;
            if (m == 2'd2) begin
              res[n[0]] = make_tok(KIND_OPER, tb, POS_W'(3), 4'(prefix_candidate), 1'b0);
              n = n + 2'd1;
              scan_mode_next = MODE_IDLE;
            end
            done = 1'b1;
          end else begin
            scan_mode_next = MODE_IDENT;
          end
        end
      end

      if (!done) begin
        if ((scan_mode_next == MODE_NUM && !is_digit(c)) ||
            (scan_mode_next == MODE_IDENT && !is_letter(c))) begin
          res[n[0]] = make_tok((scan_mode_next == MODE_NUM) ? KIND_NUMBER : KIND_IDENT,
                               tb, len, 4'd0, 1'b0);
          n = n + 2'd1;
          scan_mode_next = MODE_IDLE;
        end
        if (scan_mode_next == MODE_IDLE) begin
          token_begin_next = char_position[TB_W-1:0];
          if (is_space(c)) begin
            scan_mode_next = MODE_IDLE;
          end else if (is_digit(c)) begin
            scan_mode_next = MODE_NUM;
          end else if (c == "<" || c == ">" || c == "i" || c == "d") begin
            scan_mode_next      = MODE_OPPEND;
            prefix_matched_next = 2'd1;
            if (c == "<")      prefix_candidate_next = CAND_LT;
            else if (c == ">") prefix_candidate_next = CAND_GT;
            else if (c == "i") prefix_candidate_next = CAND_INT;
            else               prefix_candidate_next = CAND_DRV;
          end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
                       c == "=") begin
            case (c)
              "+":     res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_PLUS, 1'b0);
              "-":     res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_MINUS, 1'b0);
              "*":     res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_MUL, 1'b0);
              "/":     res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_DIV, 1'b0);
              "^":     res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_POW, 1'b0);
              default: res[n[0]] = make_tok(KIND_OPER, char_position, POS_W'(1), OP_EQ, 1'b0);
            endcase
            n = n + 2'd1;
          end else if (is_letter(c)) begin
            scan_mode_next = MODE_IDENT;
          end else begin
            error_seen_next = 1'b1;
            res[n[0]] = make_tok(KIND_ERROR, char_position, '0, 4'd0, 1'b0);
            n = n + 2'd1;
          end
        end
      end
      char_position_next = char_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= MODE_IDLE;
      token_begin      <= '0;
      char_position    <= '0;
      prefix_matched   <= '0;
      prefix_candidate <= '0;
      error_seen       <= 1'b0;
    end else if (accept) begin
      scan_mode        <= scan_mode_next;
      token_begin      <= token_begin_next;
      char_position    <= char_position_next;
      prefix_matched   <= prefix_matched_next;
      prefix_candidate <= prefix_candidate_next;
      error_seen       <= error_seen_next;
    end
  end

  assign push.count = accept ? n : 2'd0;
  assign push.tok0  = res[0];
  assign push.tok1  = res[1];

`ifndef NO_ASSERTIONS
  // An end-of-text beat always yields its closing token in the last slot.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && char_beat.end_of_text) |->
      ((push.count == 2'd1 && push.tok0.last) || (push.count == 2'd2 && push.tok1.last)))
    else $error("end of text did not produce a last token");

  // The position counter never runs past the text limit.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    char_position <= POS_W'(MAX_TEXT))
    else $error("character position exceeded the text limit");
`endif

endmodule

### rtl/exlex_queue.sv
// Token queue between the scanner and the output stage: two writes, one read.
module exlex_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  exlex_pkg::push_t      push,
  output logic                  room,
  input  logic                  pop,
  output logic                  nonempty,
  output exlex_pkg::tok_beat_t  head
);
  import exlex_pkg::*;

  tok_beat_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign room     = count <= (Q_AW + 1)'(Q_DEPTH - 2);
  assign nonempty = count != '0;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0)
      mem[wr_ptr] <= push.tok0;
    if (push.count == 2'd2)
      mem[wr_ptr + Q_AW'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.count);
      if (pop)
        rd_ptr <= rd_ptr + Q_AW'(1);
      count <= count + (Q_AW + 1)'(push.count) - (Q_AW + 1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  // The scanner only writes when two slots are free, so the queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("token queue written without room");
`endif

endmodule

### rtl/exlex_back.sv
// Output stage: registers the head of the token queue and presents it downstream.
module exlex_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  nonempty,
  input  exlex_pkg::tok_beat_t  head,
  output logic                  pop,
  output logic                  tok_valid,
  input  logic                  tok_ready,
  output exlex_pkg::tok_beat_t  tok_beat
);
  import exlex_pkg::*;

  assign pop = nonempty && (!tok_valid || tok_ready);

  always_ff @(posedge clk) begin
    if (rst)
      tok_valid <= 1'b0;
    else if (pop)
      tok_valid <= 1'b1;
    else if (tok_ready)
      tok_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop)
      tok_beat <= head;
  end

`ifndef NO_ASSERTIONS
  // An empty output register is refilled as soon as the queue holds a token.
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (!tok_valid && nonempty) |=> tok_valid)
    else $error("output register not refilled from a waiting token");
`endif

endmodule

### rtl/expression_lexer_core.sv
// Top level of the streaming expression lexer.
//
// Usage: text arrives one character per beat on the char channel
// (char_valid/char_ready/char_beat). A beat with end_of_text set closes the
// text: any pending token is flushed, an end token marked last follows, and
// the scanner rearms for a new text. Tokens leave on the tok channel
// (tok_valid/tok_ready/tok_beat), one per beat, in text order.
// Throughput: one character per cycle while the token queue has two free
// slots; a character yields zero, one or two tokens and the output stage
// drains one token per cycle while tok_ready is high, so sustained rate
// is set by that single output beat per cycle. A token made by an accepted
// character is written into the queue, then registered onto tok_beat.
// Reset (rst, synchronous) clears the scanner state, empties the queue and
// drops tok_valid. When the receiver stalls, the output register holds its
// token, the four-entry queue fills, and char_ready falls once fewer than
// two slots are free; no token is ever lost or duplicated.
module expression_lexer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  exlex_pkg::char_beat_t char_beat,
  output logic                  tok_valid,
  input  logic                  tok_ready,
  output exlex_pkg::tok_beat_t  tok_beat
);
  import exlex_pkg::*;

  push_t     push;
  logic      room;
  logic      pop;
  logic      nonempty;
  tok_beat_t head;

  // The front end scans characters and writes the tokens they complete.
  exlex_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_beat  (char_beat),
    .room       (room),
    .push       (push)
  );

  // The queue decouples scanning from downstream stalls.
  exlex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  // The back end presents one registered token per beat.
  exlex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_beat  (tok_beat)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for the expression lexer core: random texts, handshake stalls.
module tb;
  import exlex_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_BEATS   = 1100;
  localparam int PHASE_SLICES   = 8;
  localparam int MAX_REPORTS    = 40;

  // Operator codes that the package leaves unnamed.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_GE   = 4'd1;
  localparam logic [3:0] OP_INT  = 4'd2;
  localparam logic [3:0] OP_DRV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd11;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_beat_t char_beat = '0;
  logic       tok_valid;
  logic       tok_ready = 1'b0;
  tok_beat_t  tok_beat;

  expression_lexer_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_beat  (char_beat),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_beat   (tok_beat)
  );

  char_beat_t  text_beats[$];
  tok_beat_t   lexed_tokens[$];
  int unsigned beats_queued = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Lexer state mirrored by the predictor.
  scan_mode_t  lx_mode;
  int unsigned lx_begin;
  int unsigned lx_pos;
  int unsigned lx_matched;
  logic [1:0]  lx_cand;
  bit          lx_halted;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank_char(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit single_op(input logic [7:0] c, output logic [3:0] code);
    code = OP_NONE;
    case (c)
      "+": code = OP_PLUS;
      "-": code = OP_MINUS;
      "*": code = OP_MUL;
      "/": code = OP_DIV;
      "^": code = OP_POW;
      "=": code = OP_EQ;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit is_known_char(logic [7:0] c);
    logic [3:0] code;
    return is_num_char(c) || is_alpha_char(c) || is_blank_char(c) || c == "<" ||
           c == ">" || single_op(c, code);
  endfunction

  function automatic logic [7:0] keyword_letter(logic [1:0] cand, int unsigned idx);
    string word;
    word = (cand == CAND_INT) ? "int" : "drv";
    return word[idx];
  endfunction

  function automatic void lex_rearm();
    lx_mode    = MODE_IDLE;
    lx_begin   = 0;
    lx_pos     = 0;
    lx_matched = 0;
    lx_cand    = CAND_LT;
    lx_halted  = 1'b0;
  endfunction

  function automatic void emit_token(logic [2:0] kind, int unsigned start, int unsigned len,
                                     logic [3:0] code, bit last);
    tok_beat_t t;
    t.kind           = kind;
    t.start_position = (start > 4095) ? 12'hFFF : 12'(start);
    t.token_length   = (len > 8191) ? 13'h1FFF : 13'(len);
    t.operator_code  = code;
    t.last           = last;
    lexed_tokens.push_back(t);
  endfunction

  // Emits the token that is open at the current position.
  function automatic void lex_flush();
    case (lx_mode)
      MODE_NUM:   emit_token(KIND_NUMBER, lx_begin, lx_pos - lx_begin, OP_NONE, 1'b0);
      MODE_IDENT: emit_token(KIND_IDENT, lx_begin, lx_pos - lx_begin, OP_NONE, 1'b0);
      MODE_OPPEND: begin
        if (lx_cand == CAND_LT || lx_cand == CAND_GT) begin
          emit_token(KIND_OPER, lx_begin, 1, (lx_cand == CAND_LT) ? OP_LT : OP_GT, 1'b0);
        end else begin
          emit_token(KIND_IDENT, lx_begin, lx_pos - lx_begin, OP_NONE, 1'b0);
        end
      end
      default: ;
    endcase
    lx_mode = MODE_IDLE;
  endfunction

  function automatic void start_token(logic [7:0] c);
    logic [3:0] code;
    lx_begin = lx_pos;
    if (is_blank_char(c)) begin
      return;
    end
    if (is_num_char(c)) begin
      lx_mode = MODE_NUM;
    end else if (c == "<" || c == ">" || c == "i" || c == "d") begin
      lx_mode    = MODE_OPPEND;
      lx_matched = 1;
      case (c)
        "<":     lx_cand = CAND_LT;
        ">":     lx_cand = CAND_GT;
        "i":     lx_cand = CAND_INT;
        default: lx_cand = CAND_DRV;
      endcase
    end else if (single_op(c, code)) begin
      emit_token(KIND_OPER, lx_pos, 1, code, 1'b0);
    end else if (is_alpha_char(c)) begin
      lx_mode = MODE_IDENT;
    end else begin
      lx_halted = 1'b1;
      emit_token(KIND_ERROR, lx_pos, 0, OP_NONE, 1'b0);
    end
  endfunction

  // Predicts the tokens caused by one accepted character beat.
  function automatic void lex_char(char_beat_t b);
    logic [7:0]  c;
    int unsigned m;
    c = b.character;
    if (b.end_of_text) begin
      if (!lx_halted) lex_flush();
      emit_token(KIND_END, lx_pos, 0, OP_NONE, 1'b1);
      lex_rearm();
      return;
    end
    if (lx_halted) return;
    if (lx_pos >= MAX_TEXT) begin
      lex_flush();
      lx_halted = 1'b1;
      emit_token(KIND_ERROR, lx_pos, 0, OP_NONE, 1'b0);
      return;
    end
    if (lx_mode == MODE_OPPEND) begin
      if (lx_cand == CAND_LT || lx_cand == CAND_GT) begin
        lx_mode = MODE_IDLE;
        if (c == "=") begin
          emit_token(KIND_OPER, lx_begin, 2, (lx_cand == CAND_LT) ? OP_LE : OP_GE, 1'b0);
          lx_pos++;
          return;
        end
        emit_token(KIND_OPER, lx_begin, 1, (lx_cand == CAND_LT) ? OP_LT : OP_GT, 1'b0);
      end else begin
        m = (lx_matched > 2) ? 2 : lx_matched;
        if (c == keyword_letter(lx_cand, m)) begin
          lx_matched = m + 1;
          if (lx_matched == 3) begin
            emit_token(KIND_OPER, lx_begin, 3, (lx_cand == CAND_INT) ? OP_INT : OP_DRV, 1'b0);
            lx_mode = MODE_IDLE;
          end
          lx_pos++;
          return;
        end
        // A partial keyword continues as an ordinary identifier.
        lx_mode = MODE_IDENT;
      end
    end
    if ((lx_mode == MODE_NUM && !is_num_char(c)) || (lx_mode == MODE_IDENT && !is_alpha_char(c)))
      lex_flush();
    if (lx_mode == MODE_IDLE) start_token(c);
    lx_pos++;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    char_beat_t cb;
    cb.character   = b;
    cb.end_of_text = 1'b0;
    text_beats.push_back(cb);
    beats_queued++;
  endfunction

  function automatic void push_end();
    char_beat_t cb;
    cb.character   = 8'($urandom);
    cb.end_of_text = 1'b1;
    text_beats.push_back(cb);
    beats_queued++;
  endfunction

  function automatic void push_word(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(3) == 0) ? "A" : "a";
    return 8'(base + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? " " : 8'(9 + k);
  endfunction

  function automatic logic [7:0] rand_unknown();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_known_char(b));
    return b;
  endfunction

  function automatic string op_word(int k);
    case (k)
      0: return "<=";
      1: return ">=";
      2: return "int";
      3: return "drv";
      4: return "+";
      5: return "-";
      6: return "*";
      7: return "/";
      8: return "^";
      9: return "=";
      10: return "<";
      default: return ">";
    endcase
  endfunction

  function automatic string stem_word(int k);
    case (k)
      0: return "int";
      1: return "drv";
      2: return "in";
      3: return "dr";
      4: return "i";
      5: return "d";
      6: return "integral";
      default: return "drive";
    endcase
  endfunction

  // One text of random tokens; a few texts are raw noise or hit an unknown character.
  function automatic void gen_text();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
      push_end();
      return;
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(10))
        0, 1: repeat ($urandom_range(1, 5)) push_byte(8'("0" + $urandom_range(9)));
        2, 3: repeat ($urandom_range(1, 6)) push_byte(rand_letter());
        4, 5: begin
          push_word(stem_word($urandom_range(7)));
          if ($urandom_range(1) == 1) push_byte(rand_letter());
        end
        6, 7, 8: push_word(op_word($urandom_range(11)));
        9: push_byte(rand_blank());
        default: begin
          if ($urandom_range(3) == 0) begin
            push_byte(rand_unknown());
            repeat ($urandom_range(3)) push_byte(8'($urandom));
          end else begin
            push_byte(rand_blank());
          end
        end
      endcase
      if ($urandom_range(2) == 0) push_byte(rand_blank());
    end
    push_end();
  endfunction

  task automatic wait_drained();
    while (text_beats.size() != 0) @(negedge clk);
  endtask

  function automatic void note_field(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  function automatic void check_token(tok_beat_t want, tok_beat_t got);
    if (got.kind !== want.kind) note_field("kind", want.kind, got.kind);
    if (got.start_position !== want.start_position)
      note_field("start_position", want.start_position, got.start_position);
    if (got.token_length !== want.token_length)
      note_field("token_length", want.token_length, got.token_length);
    if (got.operator_code !== want.operator_code)
      note_field("operator_code", want.operator_code, got.operator_code);
    if (got.last !== want.last) note_field("last", want.last, got.last);
  endfunction

  // Character driver: predicts on each accepted beat, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready) lex_char(char_beat);
      if (!char_valid || char_ready) begin
        if (text_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          char_beat  <= text_beats.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Token monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      tok_ready <= 1'b0;
    end else begin
      tok_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (tok_valid && tok_ready) begin
        if (lexed_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: token with nothing expected, kind %0d start %0d length %0d",
                     $time, tok_beat.kind, tok_beat.start_position, tok_beat.token_length);
        end else begin
          check_token(lexed_tokens.pop_front(), tok_beat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (tok_valid && tok_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned slice_goal;
    lex_rearm();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every operator, a pending '<' that falls back, then an empty text.
    push_word("<=>=intdrv+-*/^=<x>9");
    push_end();
    push_end();
    // Partial keywords become identifiers; NUL is an error and later bytes are ignored.
    push_word("in dr");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_end();
    wait_drained();

    for (int slice = 0; slice < PHASE_SLICES; slice++) begin
      case (slice % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin sender_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      slice_goal = beats_queued + RANDOM_BEATS / PHASE_SLICES;
      while (beats_queued < slice_goal) gen_text();
      wait_drained();
    end

    while (char_valid) @(negedge clk);
    while (lexed_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
